// File: hdl/soft_knee_compressor_defines.svh
// Assertion macros used by the compressor datapath.
// Uses the clk_i / rst_ni names of the including module.
`ifndef SOFT_KNEE_COMPRESSOR_DEFINES_SVH
`define SOFT_KNEE_COMPRESSOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SKC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition in one cycle implies an outcome in the next.
`define SKC_ASSERT_NEXT(name, cond, nxt, msg) \
  `SKC_ASSERT(name, (cond) |=> (nxt), msg)

`endif

// File: hdl/skc_pkg.sv
// Shared types, constants and lookup tables for the soft-knee compressor.
// No dependencies; imported by the interface, datapath, controller and top-level files.
`default_nettype none

package skc_pkg;

  localparam int LANES      = 8;
  localparam int LANE_W     = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int RED_W      = 15;
  localparam int RED_MAX    = 32767;
  localparam int LVL_W      = 18;

  localparam logic signed [LVL_W-1:0] SILENCE_DB  = -18'sd30720;
  localparam logic [18:0]             DB_PER_LOG2 = 19'd394566;
  localparam logic [13:0]             LOG2_PER_DB = 14'd10885;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 4'd0,
    CFG_KNEE      = 4'd1,
    CFG_INV_RATIO = 4'd2,
    CFG_ATTACK    = 4'd3,
    CFG_RELEASE   = 4'd4,
    CFG_MAKEUP    = 4'd5,
    CFG_CHANNELS  = 4'd6,
    CFG_ENABLE    = 4'd7
  } skc_cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] threshold;
    logic [12:0]        knee;
    logic [16:0]        inv_ratio;
    logic [15:0]        attack;
    logic [15:0]        rel_coef;
    logic [15:0]        makeup;
    logic [3:0]         chan_cnt;
    logic               enable;
  } skc_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DET, ST_ENV1, ST_ENV2, ST_NINIT, ST_NORM, ST_LOG1, ST_LOG2,
    ST_LOG3, ST_GR, ST_SQ, ST_CSQ, ST_DIV, ST_RED, ST_EXP1, ST_EXP2, ST_EXP3,
    ST_EXP4, ST_LMUL, ST_LACC, ST_PASS, ST_DONE
  } skc_state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_DET, CMD_ENV1, CMD_ENV2, CMD_NINIT, CMD_SILENT,
    CMD_NORM, CMD_LOG1, CMD_LOG2, CMD_LOG3, CMD_GR, CMD_SQ, CMD_CSQ, CMD_DIV,
    CMD_RED, CMD_EXP1, CMD_EXP2, CMD_EXP3, CMD_EXP4, CMD_LMUL, CMD_LACC,
    CMD_PASS, CMD_PUSH
  } skc_cmd_e;

  typedef struct packed {
    skc_cmd_e cmd;
  } skc_ctrl_t;

  typedef struct packed {
    logic env_zero;
    logic norm_done;
    logic knee;
    logic div_last;
    logic lane_last;
    logic out_free;
  } skc_stat_t;

  // log2(1 + i/16) in Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] y;
    unique case (i)
      5'd0:    y = 17'd0;
      5'd1:    y = 17'd5732;
      5'd2:    y = 17'd11136;
      5'd3:    y = 17'd16248;
      5'd4:    y = 17'd21098;
      5'd5:    y = 17'd25711;
      5'd6:    y = 17'd30109;
      5'd7:    y = 17'd34312;
      5'd8:    y = 17'd38336;
      5'd9:    y = 17'd42196;
      5'd10:   y = 17'd45904;
      5'd11:   y = 17'd49472;
      5'd12:   y = 17'd52911;
      5'd13:   y = 17'd56229;
      5'd14:   y = 17'd59434;
      5'd15:   y = 17'd62534;
      5'd16:   y = 17'd65536;
      default: y = 17'd0;
    endcase
    return y;
  endfunction

  // 2^(-i/16) in Q16
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] y;
    unique case (i)
      5'd0:    y = 17'd65536;
      5'd1:    y = 17'd62757;
      5'd2:    y = 17'd60097;
      5'd3:    y = 17'd57549;
      5'd4:    y = 17'd55109;
      5'd5:    y = 17'd52773;
      5'd6:    y = 17'd50535;
      5'd7:    y = 17'd48393;
      5'd8:    y = 17'd46341;
      5'd9:    y = 17'd44376;
      5'd10:   y = 17'd42495;
      5'd11:   y = 17'd40693;
      5'd12:   y = 17'd38968;
      5'd13:   y = 17'd37316;
      5'd14:   y = 17'd35734;
      5'd15:   y = 17'd34219;
      5'd16:   y = 17'd32768;
      default: y = 17'd0;
    endcase
    return y;
  endfunction

endpackage

`default_nettype wire

// File: hdl/skc_if.sv
// Valid/ready channel interfaces: input frames, result frames, register writes.
// Depends on skc_pkg for the configuration index and data widths.
`default_nettype none

interface skc_frame_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_0;
  logic signed [SAMPLE_BITS-1:0] sample_1;
  logic signed [SAMPLE_BITS-1:0] sample_2;
  logic signed [SAMPLE_BITS-1:0] sample_3;
  logic signed [SAMPLE_BITS-1:0] sample_4;
  logic signed [SAMPLE_BITS-1:0] sample_5;
  logic signed [SAMPLE_BITS-1:0] sample_6;
  logic signed [SAMPLE_BITS-1:0] sample_7;
  modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                  sample_5, sample_6, sample_7, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                sample_5, sample_6, sample_7, output ready);
endinterface

interface skc_result_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_0;
  logic signed [SAMPLE_BITS-1:0] out_1;
  logic signed [SAMPLE_BITS-1:0] out_2;
  logic signed [SAMPLE_BITS-1:0] out_3;
  logic signed [SAMPLE_BITS-1:0] out_4;
  logic signed [SAMPLE_BITS-1:0] out_5;
  logic signed [SAMPLE_BITS-1:0] out_6;
  logic signed [SAMPLE_BITS-1:0] out_7;
  logic [14:0]                   reduction_db;
  logic [14:0]                   peak_reduction_db;
  logic                          clipped;
  modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                  out_7, reduction_db, peak_reduction_db, clipped, input ready);
  modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                out_7, reduction_db, peak_reduction_db, clipped, output ready);
endinterface

interface skc_cfg_if import skc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/skc_datapath.sv
// Compressor datapath: detector, envelope, log, gain computer, divider, gain stage.
// Depends on skc_pkg; sequenced by skc_controller through skc_ctrl_t commands.
`default_nettype none
`include "soft_knee_compressor_defines.svh"

module skc_datapath import skc_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  skc_cfg_t                      cfg_i,
  input  skc_ctrl_t                     ctrl_i,
  output skc_stat_t                     stat_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i [LANES],
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o [LANES],
  output logic [RED_W-1:0]              out_red_o,
  output logic [RED_W-1:0]              out_peak_o,
  output logic                          out_clip_o
);

  localparam int SB   = SAMPLE_BITS;
  localparam int FRAC = SB - 1;
  localparam int PW   = (SB + 34 > 61) ? SB + 34 : 61;

  // working registers
  logic signed [SB-1:0] s_q [LANES];
  logic signed [SB-1:0] res_q [LANES];
  logic [SB-1:0]        det_q, env_q, x_q;
  logic [4:0]           sh_q;
  logic [SB+15:0]       p1_q;
  logic [SB+7:0]        frp_q;
  logic [20:0]          neg_q;
  logic signed [LVL_W-1:0] level_q;
  logic                 knee_q, above_q;
  logic [14:0]          x2_q;
  logic [18:0]          abv_q;
  logic [29:0]          sq_q;
  logic [47:0]          rem_q;
  logic [15:0]          quo_q;
  logic [3:0]           bit_q;
  logic [RED_W-1:0]     red_q, max_red_q;
  logic [20:0]          nlog_q;
  logic [23:0]          mdiff_q;
  logic [16:0]          mant_q;
  logic [32:0]          total_q;
  logic [SB+15:0]       plo_q;
  logic [SB+16:0]       phi_q;
  logic [LANE_W-1:0]    lane_q;
  logic                 clip_q;

  // result register
  logic                 ov_q;
  logic signed [SB-1:0] o_s_q [LANES];
  logic [RED_W-1:0]     o_red_q, o_peak_q;
  logic                 o_clip_q;

  // combinational terms
  logic [3:0]           n_act;
  logic [SB-1:0]        mag_l [LANES];
  logic [SB-1:0]        det_d;
  logic [15:0]          coef;
  logic [16:0]          coef_c;
  logic [SB+15:0]       p1_d;
  logic [SB+16:0]       p2_d;
  logic [SB+17:0]       env_sum;
  logic [3:0]           lidx;
  logic [12:0]          ldiff;
  logic [SB+7:0]        frp_d;
  logic [SB+8:0]        frr;
  logic [16:0]          fr;
  logic [20:0]          neg_d;
  logic [39:0]          lvl_prod;
  logic signed [LVL_W-1:0] level_d;
  logic signed [20:0]   lvl2, t2, kk, x2w;
  logic signed [18:0]   dl;
  logic [16:0]          dpos, r_sat, c_cut;
  logic [34:0]          abv_w;
  logic                 knee_d, above_d;
  logic [29:0]          sq_d;
  logic [47:0]          num_w, den_sh;
  logic [18:0]          red_raw;
  logic [RED_W-1:0]     red_d;
  logic [28:0]          nlog_w;
  logic [3:0]           eidx;
  logic [11:0]          ediff;
  logic [23:0]          mdiff_d;
  logic [24:0]          mrnd;
  logic [16:0]          mant_d;
  logic [32:0]          total_d;
  logic signed [SB-1:0] lsamp;
  logic                 lneg, lclip;
  logic [SB-1:0]        lmag, qlo, lval;
  logic [SB+15:0]       plo_d;
  logic [SB+16:0]       phi_d;
  logic [PW-1:0]        prod, rnd, qv, lim, qs;
  logic [5:0]           shamt;

  always_comb begin
    if (cfg_i.chan_cnt == 4'd0) begin
      n_act = 4'd1;
    end else if (cfg_i.chan_cnt > 4'(MAX_CHANNELS)) begin
      n_act = 4'(MAX_CHANNELS);
    end else begin
      n_act = cfg_i.chan_cnt;
    end

    // peak detector over the (already masked) lanes
    det_d = '0;
    for (int i = 0; i < LANES; i++) begin
      mag_l[i] = s_q[i][SB-1] ? (~$unsigned(s_q[i]) + 1'b1) : $unsigned(s_q[i]);
      if (mag_l[i] > det_d) det_d = mag_l[i];
    end

    // one-pole envelope
    coef    = (det_q > env_q) ? cfg_i.attack : cfg_i.rel_coef;
    coef_c  = 17'h10000 - {1'b0, coef};
    p1_d    = coef * env_q;
    p2_d    = coef_c * det_q;
    env_sum = (SB+18)'(p1_q) + (SB+18)'(p2_d) + (SB+18)'(32768);

    // log2 of the normalized envelope, table plus interpolation
    lidx     = x_q[FRAC-1:FRAC-4];
    ldiff    = 13'(log2_tab(5'(lidx) + 5'd1) - log2_tab({1'b0, lidx}));
    frp_d    = ldiff * x_q[FRAC-5:0];
    frr      = {1'b0, frp_q} + ((SB+9)'(1) << (FRAC - 5));
    fr       = log2_tab({1'b0, lidx}) + 17'(frr[SB+8:FRAC-4]);
    neg_d    = {sh_q, 16'h0000} - {4'h0, fr};
    lvl_prod = neg_q * DB_PER_LOG2 + 40'd8388608;
    level_d  = -$signed({2'b00, lvl_prod[39:24]});

    // gain computer
    lvl2    = 21'(level_q) <<< 1;
    t2      = 21'(cfg_i.threshold) <<< 1;
    kk      = $signed({8'd0, cfg_i.knee});
    knee_d  = (cfg_i.knee != 13'd0) && (lvl2 > t2 - kk) && (lvl2 < t2 + kk);
    x2w     = lvl2 - t2 + kk;
    above_d = level_q > cfg_i.threshold;
    dl      = 19'(level_q) - 19'(cfg_i.threshold);
    dpos    = dl[16:0];
    r_sat   = (cfg_i.inv_ratio > 17'h10000) ? 17'h10000 : cfg_i.inv_ratio;
    c_cut   = 17'h10000 - r_sat;
    abv_w   = dpos * c_cut + 35'd32768;
    sq_d    = x2_q * x2_q;
    num_w   = c_cut * sq_q + (48'(cfg_i.knee) << 18);
    den_sh  = 48'(cfg_i.knee) << (6'd19 + 6'(bit_q));
    red_raw = knee_q ? 19'(quo_q) : (above_q ? abv_q : 19'd0);
    red_d   = (red_raw > 19'(RED_MAX)) ? RED_W'(RED_MAX) : red_raw[RED_W-1:0];

    // reduction to linear gain
    nlog_w  = red_q * LOG2_PER_DB + 29'd128;
    eidx    = nlog_q[15:12];
    ediff   = 12'(exp2_tab({1'b0, eidx}) - exp2_tab(5'(eidx) + 5'd1));
    mdiff_d = ediff * nlog_q[11:0];
    mrnd    = {1'b0, mdiff_q} + 25'd2048;
    mant_d  = exp2_tab({1'b0, eidx}) - 17'(mrnd[24:12]);
    total_d = mant_q * cfg_i.makeup;

    // per-lane gain, split into two partial products
    lsamp = s_q[lane_q];
    lneg  = lsamp[SB-1];
    lmag  = lneg ? (~$unsigned(lsamp) + 1'b1) : $unsigned(lsamp);
    plo_d = lmag * total_q[15:0];
    phi_d = lmag * total_q[32:16];
    prod  = PW'(plo_q) + (PW'(phi_q) << 16);
    shamt = 6'd28 + {1'b0, nlog_q[20:16]};
    rnd   = PW'(1) << (shamt - 6'd1);
    qv    = (prod + rnd) >> shamt;
    lim   = lneg ? (PW'(1) << FRAC) : ((PW'(1) << FRAC) - PW'(1));
    lclip = qv > lim;
    qs    = lclip ? lim : qv;
    qlo   = qs[SB-1:0];
    lval  = lneg ? (~qlo + 1'b1) : qlo;
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_LOAD: begin
        for (int i = 0; i < LANES; i++) begin
          s_q[i] <= (4'(i) < n_act) ? sample_i[i] : '0;
        end
      end
      CMD_DET:    det_q <= det_d;
      CMD_ENV1:   p1_q <= p1_d;
      CMD_NINIT: begin
        x_q  <= env_q;
        sh_q <= 5'd0;
      end
      CMD_SILENT: level_q <= SILENCE_DB;
      CMD_NORM: begin
        if (!x_q[FRAC]) begin
          x_q  <= x_q << 1;
          sh_q <= sh_q + 5'd1;
        end
      end
      CMD_LOG1:   frp_q <= frp_d;
      CMD_LOG2:   neg_q <= neg_d;
      CMD_LOG3:   level_q <= level_d;
      CMD_GR: begin
        knee_q  <= knee_d;
        above_q <= above_d;
        x2_q    <= x2w[14:0];
        abv_q   <= abv_w[34:16];
      end
      CMD_SQ:     sq_q <= sq_d;
      CMD_CSQ: begin
        rem_q <= num_w;
        quo_q <= '0;
        bit_q <= 4'd15;
      end
      CMD_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_q >= den_sh) begin
          rem_q        <= rem_q - den_sh;
          quo_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 4'd1;
      end
      CMD_RED:    red_q <= red_d;
      CMD_EXP1:   nlog_q <= nlog_w[28:8];
      CMD_EXP2:   mdiff_q <= mdiff_d;
      CMD_EXP3:   mant_q <= mant_d;
      CMD_EXP4: begin
        total_q <= total_d;
        lane_q  <= '0;
        clip_q  <= 1'b0;
      end
      CMD_LMUL: begin
        plo_q <= plo_d;
        phi_q <= phi_d;
      end
      CMD_LACC: begin
        res_q[lane_q] <= lval;
        clip_q        <= clip_q | lclip;
        lane_q        <= lane_q + 1'b1;
      end
      CMD_PASS: begin
        for (int i = 0; i < LANES; i++) begin
          res_q[i] <= s_q[i];
        end
        red_q  <= '0;
        clip_q <= 1'b0;
      end
      CMD_PUSH: begin
        for (int i = 0; i < LANES; i++) begin
          o_s_q[i] <= res_q[i];
        end
        o_red_q  <= red_q;
        o_peak_q <= max_red_q;
        o_clip_q <= clip_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q     <= '0;
      max_red_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (ctrl_i.cmd == CMD_ENV2) env_q <= env_sum[SB+15:16];
      if (ctrl_i.cmd == CMD_RED && red_d > max_red_q) max_red_q <= red_d;
      if (ctrl_i.cmd == CMD_PUSH) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign stat_o.env_zero  = (env_q == '0);
  assign stat_o.norm_done = x_q[FRAC];
  assign stat_o.knee      = knee_q;
  assign stat_o.div_last  = (bit_q == 4'd0);
  assign stat_o.lane_last = (lane_q == LANE_W'(LANES - 1));
  assign stat_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o  = ov_q;
  assign out_sample_o = o_s_q;
  assign out_red_o    = o_red_q;
  assign out_peak_o   = o_peak_q;
  assign out_clip_o   = o_clip_q;

  `SKC_ASSERT_NEXT(a_push_valid, ctrl_i.cmd == CMD_PUSH, ov_q, "push did not raise valid")
  `SKC_ASSERT(a_peak_ge_red, ov_q |-> (o_peak_q >= o_red_q), "peak below reduction")
  `SKC_ASSERT_NEXT(a_peak_mono, 1'b1, max_red_q >= $past(max_red_q), "peak decreased")
  `SKC_ASSERT_NEXT(a_norm_step, ctrl_i.cmd == CMD_NORM && !x_q[FRAC],
                   sh_q == $past(sh_q) + 5'd1, "normalize count slipped")

endmodule

`default_nettype wire

// File: hdl/skc_controller.sv
// Sequencer for the compressor datapath: one frame at a time through its steps.
// Depends on skc_pkg for state, command and status types.
`default_nettype none

module skc_controller import skc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      enable_i,
  input  skc_stat_t stat_i,
  output skc_ctrl_t ctrl_o
);

  skc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = enable_i ? ST_DET : ST_PASS;
      ST_DET:   state_d = ST_ENV1;
      ST_ENV1:  state_d = ST_ENV2;
      ST_ENV2:  state_d = ST_NINIT;
      ST_NINIT: state_d = stat_i.env_zero ? ST_GR : ST_NORM;
      ST_NORM:  if (stat_i.norm_done) state_d = ST_LOG1;
      ST_LOG1:  state_d = ST_LOG2;
      ST_LOG2:  state_d = ST_LOG3;
      ST_LOG3:  state_d = ST_GR;
      ST_GR:    state_d = ST_SQ;
      ST_SQ:    state_d = stat_i.knee ? ST_CSQ : ST_RED;
      ST_CSQ:   state_d = ST_DIV;
      ST_DIV:   if (stat_i.div_last) state_d = ST_RED;
      ST_RED:   state_d = ST_EXP1;
      ST_EXP1:  state_d = ST_EXP2;
      ST_EXP2:  state_d = ST_EXP3;
      ST_EXP3:  state_d = ST_EXP4;
      ST_EXP4:  state_d = ST_LMUL;
      ST_LMUL:  state_d = ST_LACC;
      ST_LACC:  state_d = stat_i.lane_last ? ST_DONE : ST_LMUL;
      ST_PASS:  state_d = ST_DONE;
      ST_DONE:  if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    ctrl_o.cmd = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctrl_o.cmd = CMD_LOAD;
      end
      ST_DET:   ctrl_o.cmd = CMD_DET;
      ST_ENV1:  ctrl_o.cmd = CMD_ENV1;
      ST_ENV2:  ctrl_o.cmd = CMD_ENV2;
      ST_NINIT: ctrl_o.cmd = stat_i.env_zero ? CMD_SILENT : CMD_NINIT;
      ST_NORM:  ctrl_o.cmd = CMD_NORM;
      ST_LOG1:  ctrl_o.cmd = CMD_LOG1;
      ST_LOG2:  ctrl_o.cmd = CMD_LOG2;
      ST_LOG3:  ctrl_o.cmd = CMD_LOG3;
      ST_GR:    ctrl_o.cmd = CMD_GR;
      ST_SQ:    ctrl_o.cmd = CMD_SQ;
      ST_CSQ:   ctrl_o.cmd = CMD_CSQ;
      ST_DIV:   ctrl_o.cmd = CMD_DIV;
      ST_RED:   ctrl_o.cmd = CMD_RED;
      ST_EXP1:  ctrl_o.cmd = CMD_EXP1;
      ST_EXP2:  ctrl_o.cmd = CMD_EXP2;
      ST_EXP3:  ctrl_o.cmd = CMD_EXP3;
      ST_EXP4:  ctrl_o.cmd = CMD_EXP4;
      ST_LMUL:  ctrl_o.cmd = CMD_LMUL;
      ST_LACC:  ctrl_o.cmd = CMD_LACC;
      ST_PASS:  ctrl_o.cmd = CMD_PASS;
      ST_DONE:  if (stat_i.out_free) ctrl_o.cmd = CMD_PUSH;
      default:  ctrl_o.cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/soft_knee_compressor.sv
// Compressed frame: from accept through detector, envelope, normalize and log (skipped for a silent envelope),
// gain computer, divider (in the knee only), exponent and the lane-serial gain to result valid;
// the gain multiplies then accumulates one lane at a time. Pass-through frame: masked input, zero reduction.
// One frame in flight: next accept in the cycle after the result loads; a full output stalls it.
// Async active-low reset: registers to their reset values, envelope and peak cleared.
// Top level: configuration registers, controller and datapath; uses skc_pkg and skc_if.
`default_nettype none

module soft_knee_compressor import skc_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  skc_frame_if.sink     in_i,
  skc_result_if.source  out_o,
  skc_cfg_if.sink       cfg_i
);

  skc_cfg_t  cfg_q;
  skc_ctrl_t ctrl;
  skc_stat_t stat;

  logic signed [SAMPLE_BITS-1:0] samp [LANES];
  logic signed [SAMPLE_BITS-1:0] osamp [LANES];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= -16'sd5120;
      cfg_q.knee      <= 13'd0;
      cfg_q.inv_ratio <= 17'd16384;
      cfg_q.attack    <= 16'd65000;
      cfg_q.rel_coef  <= 16'd65500;
      cfg_q.makeup    <= 16'd4096;
      cfg_q.chan_cnt  <= 4'd2;
      cfg_q.enable    <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_THRESHOLD: cfg_q.threshold <= cfg_i.data[15:0];
        CFG_KNEE:      cfg_q.knee      <= cfg_i.data[12:0];
        CFG_INV_RATIO: cfg_q.inv_ratio <= cfg_i.data[16:0];
        CFG_ATTACK:    cfg_q.attack    <= cfg_i.data[15:0];
        CFG_RELEASE:   cfg_q.rel_coef  <= cfg_i.data[15:0];
        CFG_MAKEUP:    cfg_q.makeup    <= cfg_i.data[15:0];
        CFG_CHANNELS:  cfg_q.chan_cnt  <= cfg_i.data[3:0];
        CFG_ENABLE:    cfg_q.enable    <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign samp[0] = in_i.sample_0;
  assign samp[1] = in_i.sample_1;
  assign samp[2] = in_i.sample_2;
  assign samp[3] = in_i.sample_3;
  assign samp[4] = in_i.sample_4;
  assign samp[5] = in_i.sample_5;
  assign samp[6] = in_i.sample_6;
  assign samp[7] = in_i.sample_7;

  assign out_o.out_0 = osamp[0];
  assign out_o.out_1 = osamp[1];
  assign out_o.out_2 = osamp[2];
  assign out_o.out_3 = osamp[3];
  assign out_o.out_4 = osamp[4];
  assign out_o.out_5 = osamp[5];
  assign out_o.out_6 = osamp[6];
  assign out_o.out_7 = osamp[7];

  skc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .enable_i   (cfg_q.enable),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  skc_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .sample_i     (samp),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_sample_o (osamp),
    .out_red_o    (out_o.reduction_db),
    .out_peak_o   (out_o.peak_reduction_db),
    .out_clip_o   (out_o.clipped)
  );

endmodule

`default_nettype wire
